/* src/mrt_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-rate timer package
// Shared constants, register map codes and types of the multi-rate timer.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // Channel count and the widths that follow from it.
  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // Fixed field widths.
  localparam int unsigned OpW    = 2;
  localparam int unsigned OfsW   = 8;
  localparam int unsigned SizeW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned TickW  = 64;
  localparam int unsigned ValW   = 31;
  localparam int unsigned CtrlW  = 3;
  localparam int unsigned StatW  = 2;

  // Item operations.
  typedef enum logic [OpW-1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpTick  = 2'd2
  } opcode_e;

  // Global register offsets.
  localparam logic [OfsW-1:0] OfsCap   = 8'hF0;
  localparam logic [OfsW-1:0] OfsIdle  = 8'hF4;
  localparam logic [OfsW-1:0] OfsFlags = 8'hF8;

  // Per-channel register offsets within the channel stride.
  localparam logic [3:0] RegIntval = 4'h0;
  localparam logic [3:0] RegTimer  = 4'h4;
  localparam logic [3:0] RegCtrl   = 4'h8;
  localparam logic [3:0] RegStat   = 4'hC;

  // Register window and channel area limits (one bit wider than the offset).
  localparam logic [OfsW:0] WinSize   = 9'h100;
  localparam logic [OfsW:0] ChanLimit = 9'(NumChannels * 16);

  // Status bit positions.
  localparam int unsigned StFlag = 0;
  localparam int unsigned StRun  = 1;

  // Interval write: load-now bit position.
  localparam int unsigned LoadBit = 31;

  // Read-only capability word: channel count minus one and counter width.
  localparam logic [DataW-1:0] CapWord =
    32'((NumChannels - 1) & 32'hF) | (32'd31 << 4);

endpackage

/* src/mrt_if.sv */
// ----------------------------------------------------------------------------
// Multi-rate timer channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mrt_req_if;
  logic                           valid;
  logic                           ready;
  logic [mrt_pkg::OpW-1:0]        opcode;
  logic [mrt_pkg::OfsW-1:0]       offset;
  logic [mrt_pkg::SizeW-1:0]      access_size;
  logic [mrt_pkg::DataW-1:0]      write_data;
  logic [mrt_pkg::TickW-1:0]      tick_cycles;
  logic                           clock_active;

  modport source (
    output valid, opcode, offset, access_size, write_data, tick_cycles, clock_active,
    input  ready
  );
  modport sink (
    input  valid, opcode, offset, access_size, write_data, tick_cycles, clock_active,
    output ready
  );
endinterface

interface mrt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mrt_pkg::DataW-1:0] read_data;
  logic                      access_ok;
  logic                      irq_raise;
  logic                      irq_lower;

  modport source (
    output valid, read_data, access_ok, irq_raise, irq_lower,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_ok, irq_raise, irq_lower,
    output ready
  );
endinterface

/* src/multi_rate_timer.sv */
// ----------------------------------------------------------------------------
// Multi-rate timer
// Four 31-bit down-counter channels behind a 256-byte register window.
// ----------------------------------------------------------------------------
// Each item (bus read, bus write or tick) is captured in an input register,
// processed against the channel state and written to a result register,
// so the block takes one item per clock while the output is not stalled
// and delivers one result per item. The input register keeps taking items
// while a result waits at the output; it stalls only when both the result
// register and the input register are full and the waiting result is not
// being taken.
// All running channels update in parallel on a tick, each with one compare
// and one subtract against the tick count saturated to 32 bits.
module multi_rate_timer (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrt_req_if.sink       in_i,
  mrt_rsp_if.source     out_o
);

  localparam int unsigned N = mrt_pkg::NumChannels;

  // Input register.
  logic                          in_valid_q;
  logic [mrt_pkg::OpW-1:0]       op_q;
  logic [mrt_pkg::OfsW-1:0]      ofs_q;
  logic [mrt_pkg::SizeW-1:0]     size_q;
  logic [mrt_pkg::DataW-1:0]     wdata_q;
  logic [mrt_pkg::TickW-1:0]     cycles_q;
  logic                          clk_act_q;

  // Result register.
  logic                          out_valid_q;
  logic [mrt_pkg::DataW-1:0]     rdata_q, rdata_d;
  logic                          ok_q, ok_d;
  logic                          raise_q, raise_d;
  logic                          lower_q, lower_d;

  // Channel state.
  logic [mrt_pkg::ValW-1:0]      intval_q [N];
  logic [mrt_pkg::ValW-1:0]      intval_d [N];
  logic [mrt_pkg::ValW-1:0]      count_q  [N];
  logic [mrt_pkg::ValW-1:0]      count_d  [N];
  logic [mrt_pkg::CtrlW-1:0]     ctrl_q   [N];
  logic [mrt_pkg::CtrlW-1:0]     ctrl_d   [N];
  logic [mrt_pkg::StatW-1:0]     stat_q   [N];
  logic [mrt_pkg::StatW-1:0]     stat_d   [N];
  logic [N-1:0]                  flags_q, flags_d;

  logic advance;
  logic fire;

  // The result register frees when empty or taken; the input register moves on then.
  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q      <= in_i.opcode;
      ofs_q     <= in_i.offset;
      size_q    <= in_i.access_size;
      wdata_q   <= in_i.write_data;
      cycles_q  <= in_i.tick_cycles;
      clk_act_q <= in_i.clock_active;
    end
  end

  // Decode of the held item.
  logic                      acc_ok;
  logic [mrt_pkg::OfsW:0]    acc_end;
  logic                      chan_area;
  logic [mrt_pkg::ChW-1:0]   ch;
  logic [3:0]                reg_sel;
  logic [mrt_pkg::DataW-1:0] step;

  always_comb begin
    acc_end   = {1'b0, ofs_q} + {6'd0, size_q};
    acc_ok    = (size_q != 3'd0) && (size_q <= 3'd4) &&
                (acc_end <= mrt_pkg::WinSize) && clk_act_q;
    chan_area = ({1'b0, ofs_q} < mrt_pkg::ChanLimit);
    ch        = ofs_q[4 +: mrt_pkg::ChW];
    reg_sel   = ofs_q[3:0];
    step      = (|cycles_q[mrt_pkg::TickW-1:mrt_pkg::DataW]) ? '1 :
                cycles_q[mrt_pkg::DataW-1:0];
  end

  // First channel that is not running.
  logic                    idle_found;
  logic [mrt_pkg::ChW-1:0] idle_idx;
  logic [mrt_pkg::DataW-1:0] idle_word;

  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!stat_q[i][mrt_pkg::StRun]) begin
        idle_found = 1'b1;
        idle_idx   = mrt_pkg::ChW'(i);
      end
    end
    idle_word = idle_found ? (32'(idle_idx) << 4) : (32'(N) << 4);
  end

  // Read mux.
  logic [mrt_pkg::DataW-1:0] read_word;

  always_comb begin
    read_word = '0;
    if (ofs_q == mrt_pkg::OfsCap) begin
      read_word = mrt_pkg::CapWord;
    end else if (ofs_q == mrt_pkg::OfsIdle) begin
      read_word = idle_word;
    end else if (ofs_q == mrt_pkg::OfsFlags) begin
      read_word = 32'(flags_q);
    end else if (chan_area) begin
      case (reg_sel)
        mrt_pkg::RegIntval: read_word = {1'b0, intval_q[ch]};
        mrt_pkg::RegTimer:  read_word = {1'b0, count_q[ch]};
        mrt_pkg::RegCtrl:   read_word = 32'(ctrl_q[ch]);
        mrt_pkg::RegStat:   read_word = 32'(stat_q[ch]);
        default:            read_word = '0;
      endcase
    end
  end

  // Next state and result of the held item.
  logic [mrt_pkg::ValW-1:0] wr_iv;

  always_comb begin
    intval_d = intval_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    stat_d   = stat_q;
    flags_d  = flags_q;
    rdata_d  = '0;
    ok_d     = 1'b0;
    raise_d  = 1'b0;
    lower_d  = 1'b0;
    wr_iv    = wdata_q[mrt_pkg::ValW-1:0];

    case (op_q)
      mrt_pkg::OpRead: begin
        if (acc_ok) begin
          ok_d    = 1'b1;
          rdata_d = read_word;
        end
      end
      mrt_pkg::OpWrite: begin
        if (acc_ok) begin
          ok_d = 1'b1;
          if (ofs_q == mrt_pkg::OfsFlags) begin
            flags_d = flags_q & ~wdata_q[N-1:0];
            lower_d = (flags_d == '0);
          end else if (chan_area) begin
            case (reg_sel)
              mrt_pkg::RegIntval: begin
                intval_d[ch] = wr_iv;
                if (wdata_q[mrt_pkg::LoadBit] || (wr_iv == '0) || (count_q[ch] == '0)) begin
                  count_d[ch] = wr_iv;
                end
                stat_d[ch][mrt_pkg::StRun] = (wr_iv != '0);
              end
              mrt_pkg::RegCtrl: begin
                ctrl_d[ch] = wdata_q[mrt_pkg::CtrlW-1:0];
              end
              mrt_pkg::RegStat: begin
                if (wdata_q[mrt_pkg::StFlag]) begin
                  stat_d[ch][mrt_pkg::StFlag] = 1'b0;
                  flags_d[ch] = 1'b0;
                  lower_d     = (flags_d == '0);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      mrt_pkg::OpTick: begin
        ok_d = 1'b1;
        if (clk_act_q && (step != '0)) begin
          // Every running channel counts down in parallel.
          for (int i = 0; i < N; i++) begin
            if (stat_q[i][mrt_pkg::StRun] && (count_q[i] != '0)) begin
              if ({1'b0, count_q[i]} <= step) begin
                count_d[i] = '0;
                stat_d[i][mrt_pkg::StFlag] = 1'b1;
                flags_d[i] = 1'b1;
                raise_d    = 1'b1;
                if ((ctrl_q[i][2:1] == 2'd0) && (intval_q[i] != '0)) begin
                  count_d[i] = intval_q[i];
                end else begin
                  stat_d[i][mrt_pkg::StRun] = 1'b0;
                end
              end else begin
                count_d[i] = count_q[i] - step[mrt_pkg::ValW-1:0];
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        intval_q[i] <= '0;
        count_q[i]  <= '0;
        ctrl_q[i]   <= '0;
        stat_q[i]   <= '0;
      end
      flags_q <= '0;
    end else if (fire) begin
      intval_q <= intval_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      stat_q   <= stat_d;
      flags_q  <= flags_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= rdata_d;
      ok_q    <= ok_d;
      raise_q <= raise_d;
      lower_q <= lower_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rdata_q;
  assign out_o.access_ok = ok_q;
  assign out_o.irq_raise = raise_q;
  assign out_o.irq_lower = lower_q;

  // Summary vectors for the checks below.
  logic [N-1:0] stat_flag_vec;
  logic [N-1:0] run_bad_vec;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      stat_flag_vec[i] = stat_q[i][mrt_pkg::StFlag];
      run_bad_vec[i]   = stat_q[i][mrt_pkg::StRun] && (intval_q[i] == '0);
    end
  end

  // A stalled input side means an item is held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q)
    else $error("input stalled with empty input register");

  // A pending interrupt flag always has its channel status flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q & ~stat_flag_vec) == '0)
    else $error("interrupt flag set without channel status flag");

  // A running channel always has a nonzero interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_bad_vec == '0)
    else $error("channel running with zero interval");

  // Raise and lower pulses never come together and only with an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (raise_q || lower_q) |-> ok_q && !(raise_q && lower_q))
    else $error("inconsistent interrupt pulses in result");

endmodule
